[rtl/tsfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tsfs_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int SIGMA_SQ       = 9;
    localparam logic [15:0] MIN_LENGTH_RESET = 16'd16;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd1024;
    localparam logic [0:0] REG_MIN_LENGTH = 1'b0;
    localparam logic [0:0] REG_MAX_LENGTH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_DECIDE,
        ST_DIV_MEAN,
        ST_WAIT_MEAN,
        ST_DIV_SQ,
        ST_WAIT_SQ,
        ST_MEAN_SQ,
        ST_VAR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic decide;
        logic start_mean;
        logic start_sq;
        logic mean_square;
        logic update_var;
        logic out_valid;
    } ctrl_t;

    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

[rtl/tsfs_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

module tsfs_divider #(
    parameter int COUNT_BITS = tsfs_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [63:0]           dividend,
    input  wire logic [COUNT_BITS-1:0] divisor,
    output logic                       done,
    output logic [63:0]                quotient
);

    localparam int CW = $clog2(65);

    logic [63:0]         quo_reg, quo_next;
    logic [COUNT_BITS:0] rem_reg, rem_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [COUNT_BITS:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[COUNT_BITS-1:0], quo_reg[63]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(64);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/tsfs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module tsfs_datapath #(
    parameter int COUNT_BITS = tsfs_pkg::COUNT_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  tsfs_pkg::ctrl_t    ctrl,
    output tsfs_pkg::status_t  status,
    input  wire logic [31:0]   sample,
    input  wire logic [31:0]   position,
    input  wire logic [15:0]   min_length,
    input  wire logic [15:0]   max_length,
    output logic               cut,
    output logic [31:0]        cut_position,
    output logic [15:0]        fragment_number,
    output logic [15:0]        fragment_fill
);

    localparam logic [COUNT_BITS-1:0] FILL_MAX = '1;

    logic signed [31:0]     smp_reg;
    logic [31:0]            pos_reg;
    logic [COUNT_BITS-1:0]  fill_reg, fill_next;
    logic signed [31:0]     mean_reg;
    logic [63:0]            msq_reg;
    logic signed [63:0]     var_reg;
    logic [15:0]            cuts_reg;
    logic                   cut_reg;
    logic [63:0]            dsq_reg;
    logic [63:0]            ssq_reg;
    logic [63:0]            mm_reg;
    logic                   neg_reg;
    logic signed [63:0]     diff;
    logic [63:0]            mag;
    logic [32:0]            ud;
    logic [66:0]            nine_v;
    logic [63:0]            vpos;
    logic                   is_cut;
    logic [COUNT_BITS-1:0]  fill_cut;
    logic [63:0]            q;
    logic                   dstart;
    logic signed [63:0]     dq;
    logic signed [63:0]     sq_diff;

    assign diff = 64'(smp_reg) - 64'(mean_reg);
    assign ud   = diff[63] ? 33'(-diff) : diff[32:0];
    assign vpos = var_reg[63] ? 64'd0 : var_reg;
    assign nine_v = {vpos, 3'b000} + 67'(vpos);
    assign sq_diff = $signed(ssq_reg) - $signed(msq_reg);

    always_comb
    begin
        is_cut = 1'b0;
        if ((32'(fill_reg) > 32'(min_length)) && ({3'b000, dsq_reg} > nine_v))
        begin
            is_cut = 1'b1;
        end
        if (32'(fill_reg) >= 32'(max_length))
        begin
            is_cut = 1'b1;
        end
        fill_cut  = is_cut ? '0 : fill_reg;
        fill_next = (fill_cut < FILL_MAX) ? fill_cut + 1'b1 : fill_cut;
    end

    always_comb
    begin
        mag = 64'd0;
        if (ctrl.start_mean)
        begin
            mag = diff[63] ? -diff : diff;
        end
        else if (ctrl.start_sq)
        begin
            mag = sq_diff[63] ? -sq_diff : sq_diff;
        end
    end

    assign dstart = ctrl.start_mean | ctrl.start_sq;
    assign dq     = neg_reg ? -$signed(q) : $signed(q);

    tsfs_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dstart),
        .dividend (mag),
        .divisor  (fill_reg),
        .done     (status.div_done),
        .quotient (q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            mean_reg <= '0;
            msq_reg  <= '0;
            var_reg  <= '0;
            cuts_reg <= '0;
            cut_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.decide)
            begin
                cut_reg  <= is_cut;
                fill_reg <= fill_next;
                if (is_cut && cuts_reg != 16'hFFFF)
                begin
                    cuts_reg <= cuts_reg + 16'd1;
                end
            end
            if (ctrl.start_sq)
            begin
                mean_reg <= 32'(64'(mean_reg) + dq);
            end
            if (ctrl.mean_square)
            begin
                msq_reg <= 64'($signed(msq_reg) + dq);
            end
            if (ctrl.update_var && 32'(fill_reg) >= 32'(min_length))
            begin
                var_reg <= $signed(msq_reg) - $signed(mm_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            smp_reg <= sample;
            pos_reg <= position;
        end
        if (ctrl.square)
        begin
            dsq_reg <= 64'(ud) * 64'(ud);
            ssq_reg <= smp_reg[31] ? 64'(33'(-64'(smp_reg))) * 64'(33'(-64'(smp_reg)))
                                   : 64'(smp_reg) * 64'(smp_reg);
        end
        if (dstart)
        begin
            neg_reg <= ctrl.start_mean ? diff[63] : sq_diff[63];
        end
        if (ctrl.mean_square)
        begin
            mm_reg <= 64'(64'(mean_reg) * 64'(mean_reg));
        end
    end

    assign cut             = cut_reg;
    assign cut_position    = cut_reg ? pos_reg : 32'd0;
    assign fragment_number = cuts_reg;
    assign fragment_fill   = 16'(fill_reg);

endmodule

`default_nettype wire

[rtl/tsfs_controller.sv]
`timescale 1ns / 1ps
`default_nettype none

module tsfs_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  tsfs_pkg::status_t  status,
    output tsfs_pkg::ctrl_t    ctrl
);

    tsfs_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsfs_pkg::ST_IDLE:      if (in_valid) state_next = tsfs_pkg::ST_SQUARE;
            tsfs_pkg::ST_SQUARE:    state_next = tsfs_pkg::ST_DECIDE;
            tsfs_pkg::ST_DECIDE:    state_next = tsfs_pkg::ST_DIV_MEAN;
            tsfs_pkg::ST_DIV_MEAN:  state_next = tsfs_pkg::ST_WAIT_MEAN;
            tsfs_pkg::ST_WAIT_MEAN: if (status.div_done) state_next = tsfs_pkg::ST_DIV_SQ;
            tsfs_pkg::ST_DIV_SQ:    state_next = tsfs_pkg::ST_WAIT_SQ;
            tsfs_pkg::ST_WAIT_SQ:   if (status.div_done) state_next = tsfs_pkg::ST_MEAN_SQ;
            tsfs_pkg::ST_MEAN_SQ:   state_next = tsfs_pkg::ST_VAR;
            tsfs_pkg::ST_VAR:       state_next = tsfs_pkg::ST_OUT;
            tsfs_pkg::ST_OUT:       if (!out_stall) state_next = tsfs_pkg::ST_IDLE;
            default:                state_next = tsfs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl             = '0;
        ctrl.load        = (state_reg == tsfs_pkg::ST_IDLE) && in_valid;
        ctrl.square      = (state_reg == tsfs_pkg::ST_SQUARE);
        ctrl.decide      = (state_reg == tsfs_pkg::ST_DECIDE);
        ctrl.start_mean  = (state_reg == tsfs_pkg::ST_DIV_MEAN);
        ctrl.start_sq    = (state_reg == tsfs_pkg::ST_DIV_SQ);
        ctrl.mean_square = (state_reg == tsfs_pkg::ST_MEAN_SQ);
        ctrl.update_var  = (state_reg == tsfs_pkg::ST_VAR);
        ctrl.out_valid   = (state_reg == tsfs_pkg::ST_OUT);
    end

    assign in_stall  = (state_reg != tsfs_pkg::ST_IDLE);
    assign out_valid = ctrl.out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsfs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");
    a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.start_mean && ctrl.start_sq))
        else $error("two divisions started together");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result waits");

endmodule

`default_nettype wire

[rtl/three_sigma_fragment_splitter.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   sample, position
// output    out        out_valid / out_stall cut, cut_position, fragment_number, fragment_fill
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
// Each input is processed in full before the next is taken: two 64-step divisions
// by the fill count on one shared radix-2 divider, plus square and update steps.
// Reset is asynchronous; it clears the statistics and the cut state and sets the
// length limits to defaults, but the sample, position and product registers are
// not reset.
// A stalled result holds, and no new input is taken until it has gone.

module three_sigma_fragment_splitter #(
    parameter int COUNT_BITS = tsfs_pkg::COUNT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] sample,
    input  wire logic [31:0] position,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             cut,
    output logic [31:0]      cut_position,
    output logic [15:0]      fragment_number,
    output logic [15:0]      fragment_fill,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_index,
    input  wire logic [15:0] cfg_data
);

    tsfs_pkg::ctrl_t   ctrl;
    tsfs_pkg::status_t status;
    logic [15:0]       min_reg;
    logic [15:0]       max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= tsfs_pkg::MIN_LENGTH_RESET;
            max_reg <= tsfs_pkg::MAX_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_index[31:1] == 31'd0)
        begin
            if (cfg_index[0] == tsfs_pkg::REG_MIN_LENGTH)
            begin
                min_reg <= cfg_data;
            end
            else
            begin
                max_reg <= cfg_data;
            end
        end
    end

    tsfs_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    tsfs_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .status          (status),
        .sample          (sample),
        .position        (position),
        .min_length      (min_reg),
        .max_length      (max_reg),
        .cut             (cut),
        .cut_position    (cut_position),
        .fragment_number (fragment_number),
        .fragment_fill   (fragment_fill)
    );

endmodule

`default_nettype wire
